FILE: hdl/bfs_hop_distance_core_macros.svh
// Assertion macros for the hop distance core checker.
`ifndef BFS_HOP_DISTANCE_CORE_MACROS_SVH
`define BFS_HOP_DISTANCE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BHD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bhd_pkg.sv
// Shared types and constants for the hop distance core.
`default_nettype none
package bhd_pkg;

  localparam int OP_W          = 2;
  localparam int NODE_FIELD_W  = 6;
  localparam int HOPS_W        = 7;
  localparam int CFG_W         = 7;
  localparam int DEF_MAX_NODES = 64;

  localparam logic [CFG_W-1:0]  NODE_COUNT_RESET = 7'd64;
  localparam logic [HOPS_W-1:0] HOPS_NONE        = 7'h7F;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

endpackage
`default_nettype wire

FILE: hdl/bhd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: hdl/bfs_hop_distance_core.sv
// Hop distance core: adjacency bit matrix with breadth-first shortest path queries.
//
// Accepts a transaction when start is high and busy is low. A clear never raises busy;
// an edge add holds busy for a single cycle. A query holds busy until the target is
// dequeued or the queue runs empty; its pace is set by the one adjacency read port (one
// row per dequeued node) and the lowest-set-bit picker that enqueues one neighbor per
// cycle, and a bad node number ends the search at once. The query result is shown on
// out_hops for exactly one cycle with out_strobe and the receiver cannot stall it;
// out_hops is -1 when the target is unreachable. Write cfg_wr_data only while busy
// is low.
`default_nettype none
module bfs_hop_distance_core
  import bhd_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OP_W-1:0]          in_op,
  input  wire logic [NODE_FIELD_W-1:0]  in_node_a,
  input  wire logic [NODE_FIELD_W-1:0]  in_node_b,
  output logic                          out_strobe,
  output logic signed [HOPS_W-1:0]      out_hops,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_W-1:0]         cfg_wr_data
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int QCNT_W = $clog2(MAX_NODES + 1);
  localparam int CNT_W  = (QCNT_W > CFG_W) ? QCNT_W : CFG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_SCAN,
    S_FETCH,
    S_LOAD
  } state_t;

  state_t                state_r;
  logic                  out_strobe_r;
  logic [HOPS_W-1:0]     out_hops_r;
  logic [CFG_W-1:0]      node_count_r;
  logic [MAX_NODES-1:0]  row_valid_r;
  logic [MAX_NODES-1:0]  visited_r;
  logic [MAX_NODES-1:0]  mask_r;
  logic [MAX_NODES-1:0]  cand_r;
  logic [NODE_W-1:0]     edge_a_r;
  logic [NODE_W-1:0]     edge_b_r;
  logic [NODE_W-1:0]     dst_r;
  logic [NODE_W-1:0]     v_r;
  logic [QCNT_W-1:0]     head_r;
  logic [QCNT_W-1:0]     tail_r;
  logic [QCNT_W-1:0]     lvl_end_r;
  logic [HOPS_W-1:0]     level_r;

  logic                  accept;
  logic [NODE_W-1:0]     src_idx;
  logic [NODE_W-1:0]     dst_idx;
  logic [CNT_W-1:0]      n_lim;
  logic [MAX_NODES-1:0]  mask_now;
  logic                  query_ok;
  logic                  edge_ok;
  logic [MAX_NODES-1:0]  low_bit;
  logic [NODE_W-1:0]     pick_idx;
  logic [MAX_NODES-1:0]  row_data;

  logic                  adj_we;
  logic [NODE_W-1:0]     adj_raddr;
  logic [MAX_NODES-1:0]  adj_wdata;
  logic [MAX_NODES-1:0]  adj_rdata;
  logic                  q_we;
  logic [NODE_W-1:0]     q_waddr;
  logic [NODE_W-1:0]     q_wdata;
  logic [NODE_W-1:0]     q_rdata;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_hops   = $signed(out_hops_r);
  assign src_idx    = NODE_W'(in_node_a);
  assign dst_idx    = NODE_W'(in_node_b);

  always_comb begin
    if (CNT_W'(node_count_r) > CNT_W'(MAX_NODES)) begin
      n_lim = CNT_W'(MAX_NODES);
    end else begin
      n_lim = CNT_W'(node_count_r);
    end
    for (int w = 0; w < MAX_NODES; w++) begin
      mask_now[w] = (CNT_W'(w) < n_lim);
    end
  end

  assign query_ok = (CNT_W'(in_node_a) < n_lim) && (CNT_W'(in_node_b) < n_lim);
  assign edge_ok  = (CNT_W'(in_node_a) < CNT_W'(MAX_NODES)) &&
                    (CNT_W'(in_node_b) < CNT_W'(MAX_NODES));

  // lowest pending neighbor
  assign low_bit = cand_r & (~cand_r + MAX_NODES'(1));

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (low_bit[i]) begin
        pick_idx = pick_idx | NODE_W'(i);
      end
    end
  end

  always_comb begin
    adj_we    = (state_r == S_EDGE);
    adj_raddr = (state_r == S_FETCH) ? q_rdata : src_idx;
    row_data  = row_valid_r[edge_a_r] ? adj_rdata : '0;
    adj_wdata = row_data | (MAX_NODES'(1) << edge_b_r);
    if (state_r == S_IDLE) begin
      q_we    = accept && (in_op == OP_QUERY) && query_ok;
      q_waddr = '0;
      q_wdata = src_idx;
    end else begin
      q_we    = (state_r == S_SCAN) && (cand_r != '0);
      q_waddr = tail_r[NODE_W-1:0];
      q_wdata = pick_idx;
    end
  end

  bhd_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_adj_ram (
    .clk     (clk),
    .wr_en   (adj_we),
    .wr_addr (edge_a_r),
    .wr_data (adj_wdata),
    .rd_addr (adj_raddr),
    .rd_data (adj_rdata)
  );

  bhd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_waddr),
    .wr_data (q_wdata),
    .rd_addr (head_r[NODE_W-1:0]),
    .rd_data (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      node_count_r <= NODE_COUNT_RESET;
      row_valid_r  <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (op_t'(in_op))
              OP_CLEAR: begin
                row_valid_r <= '0;
              end
              OP_ADD: begin
                edge_a_r <= src_idx;
                edge_b_r <= dst_idx;
                if (edge_ok) begin
                  state_r <= S_EDGE;
                end
              end
              OP_QUERY: begin
                // bad node: empty queue, search ends at once with -1
                dst_r     <= dst_idx;
                mask_r    <= mask_now;
                visited_r <= MAX_NODES'(1) << src_idx;
                cand_r    <= '0;
                head_r    <= '0;
                tail_r    <= query_ok ? QCNT_W'(1) : '0;
                lvl_end_r <= '0;
                level_r   <= HOPS_NONE;
                state_r   <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_EDGE: begin
          row_valid_r[edge_a_r] <= 1'b1;
          state_r               <= S_IDLE;
        end
        S_SCAN: begin
          if (cand_r != '0) begin
            cand_r    <= cand_r & ~low_bit;
            visited_r <= visited_r | low_bit;
            tail_r    <= tail_r + QCNT_W'(1);
          end else if (head_r == tail_r) begin
            out_strobe_r <= 1'b1;
            out_hops_r   <= HOPS_NONE;
            state_r      <= S_IDLE;
          end else begin
            head_r <= head_r + QCNT_W'(1);
            if (head_r == lvl_end_r) begin
              level_r   <= level_r + HOPS_W'(1);
              lvl_end_r <= tail_r;
            end
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          v_r <= q_rdata;
          if (q_rdata == dst_r) begin
            out_strobe_r <= 1'b1;
            out_hops_r   <= level_r;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          cand_r  <= (row_valid_r[v_r] ? adj_rdata : '0) & ~visited_r & mask_r;
          state_r <= S_SCAN;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bhd_checker.sv
// Port-level checker for the hop distance core, bound to the top level.
`default_nettype none
`include "bfs_hop_distance_core_macros.svh"
module bhd_checker
  import bhd_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic [OP_W-1:0]         in_op,
  input wire logic                    out_strobe,
  input wire logic signed [HOPS_W-1:0] out_hops
);

  `BHD_ASSERT_NEXT(a_query_busy, start && !busy && (in_op == OP_QUERY), busy, "query not busy")
  `BHD_ASSERT_NEXT(a_no_result_other, start && !busy && (in_op != OP_QUERY), !out_strobe, "result without query")
  `BHD_ASSERT_NOW(a_result_idle, out_strobe, !busy, "result while busy")
  `BHD_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe repeated")
  `BHD_ASSERT_NOW(a_hops_range, out_strobe && out_hops[HOPS_W-1], out_hops == -1, "hops out of range")

endmodule

bind bfs_hop_distance_core bhd_checker u_bhd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_op      (in_op),
  .out_strobe (out_strobe),
  .out_hops   (out_hops)
);
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for bfs_hop_distance_core: random graphs and hop-count queries checked against a mirror.
module tb_top;
  import bhd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 300;
  localparam int RUN_LIMIT = 12_000_000;

  class hop_mirror;
    logic [DEF_MAX_NODES-1:0] adj [DEF_MAX_NODES];
    logic [CFG_W-1:0] node_count;
    logic signed [HOPS_W-1:0] pending_hops [$];
    int errors;

    function new();
      foreach (adj[i]) adj[i] = '0;
      node_count = NODE_COUNT_RESET;
      errors = 0;
    endfunction

    function logic signed [HOPS_W-1:0] shortest_hops(int src, int dst);
      int n;
      int head;
      int tail;
      int v;
      int hop_of [DEF_MAX_NODES];
      int order [DEF_MAX_NODES];
      n = (node_count > DEF_MAX_NODES) ? DEF_MAX_NODES : int'(node_count);
      if (src >= n || dst >= n) return HOPS_NONE;
      foreach (hop_of[i]) hop_of[i] = -1;
      hop_of[src] = 0;
      order[0] = src;
      head = 0;
      tail = 1;
      while (head < tail) begin
        v = order[head];
        head++;
        for (int w = 0; w < n; w++) begin
          if (adj[v][w] && hop_of[w] < 0) begin
            hop_of[w] = hop_of[v] + 1;
            order[tail] = w;
            tail++;
          end
        end
      end
      if (hop_of[dst] < 0) return HOPS_NONE;
      return HOPS_W'(hop_of[dst]);
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [NODE_FIELD_W-1:0] a,
                            logic [NODE_FIELD_W-1:0] b);
      case (op)
        OP_CLEAR: begin
          foreach (adj[i]) adj[i] = '0;
        end
        OP_ADD: begin
          adj[a][b] = 1'b1;
        end
        OP_QUERY: begin
          pending_hops = {pending_hops, shortest_hops(a, b)};
        end
        default: ;
      endcase
    endfunction

    function void check_hops(logic signed [HOPS_W-1:0] got);
      logic signed [HOPS_W-1:0] want;
      if (pending_hops.size() == 0) begin
        $error("unexpected transaction: hops actual %0d", got);
        errors++;
      end else begin
        want = pending_hops.pop_front();
        if (got !== want) begin
          $error("hops: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function void check_drained();
      foreach (pending_hops[i]) begin
        $error("hops: expected %0d, actual none", pending_hops[i]);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [OP_W-1:0] in_op;
  logic [NODE_FIELD_W-1:0] in_node_a;
  logic [NODE_FIELD_W-1:0] in_node_b;
  logic out_strobe;
  logic signed [HOPS_W-1:0] out_hops;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  hop_mirror mirror = new();
  bit no_gaps;

  bfs_hop_distance_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_node_a   (in_node_a),
    .in_node_b   (in_node_b),
    .out_strobe  (out_strobe),
    .out_hops    (out_hops),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) mirror.check_hops(out_hops);
      if (cfg_wr_en) mirror.node_count = cfg_wr_data;
      if (start && !busy) mirror.note_item(in_op, in_node_a, in_node_b);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [NODE_FIELD_W-1:0] a,
                           input logic [NODE_FIELD_W-1:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_op = op;
    in_node_a = a;
    in_node_b = b;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (mirror.pending_hops.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic run_phase(input int items, inout int sent);
    int span;
    int r;
    logic [OP_W-1:0] op;
    logic [NODE_FIELD_W-1:0] a;
    logic [NODE_FIELD_W-1:0] b;
    span = ($urandom_range(0, 3) == 0) ? DEF_MAX_NODES : $urandom_range(2, 16);
    r = $urandom_range(0, 99);
    if (r < 5) write_node_count('0);
    else if (r < 15) write_node_count(CFG_W'($urandom_range(65, 127)));
    else if (r < 55) write_node_count(CFG_W'(span));
    else write_node_count(CFG_W'($urandom_range(1, 64)));
    no_gaps = ($urandom_range(0, 9) < 3);
    if ($urandom_range(0, 1) == 1) begin
      send_item(OP_CLEAR, NODE_FIELD_W'($urandom), NODE_FIELD_W'($urandom));
      sent++;
    end
    repeat (items) begin
      r = $urandom_range(0, 99);
      a = NODE_FIELD_W'($urandom_range(0, span - 1));
      b = NODE_FIELD_W'($urandom_range(0, span - 1));
      if (r < 8) begin
        op = OP_W'($urandom_range(0, 3));
        a = NODE_FIELD_W'($urandom);
        b = NODE_FIELD_W'($urandom);
      end else if (r < 11) begin
        op = OP_CLEAR;
      end else if (r < 60) begin
        op = OP_ADD;
        if ($urandom_range(0, 9) < 3) b = NODE_FIELD_W'((a + 1) % span);
      end else begin
        op = OP_QUERY;
      end
      send_item(op, a, b);
      if (op != OP_UNUSED) sent++;
    end
  endtask

  initial begin
    int sent;
    int waited;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_CLEAR;
    in_node_a = '0;
    in_node_b = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    no_gaps = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty graph, ring through node 63, register extremes
    send_item(OP_QUERY, 6'd0, 6'd0);
    send_item(OP_QUERY, 6'd0, 6'd63);
    send_item(OP_ADD, 6'd0, 6'd1);
    send_item(OP_ADD, 6'd1, 6'd2);
    send_item(OP_ADD, 6'd2, 6'd63);
    send_item(OP_ADD, 6'd63, 6'd0);
    send_item(OP_ADD, 6'd0, 6'd1);
    send_item(OP_QUERY, 6'd0, 6'd63);
    send_item(OP_QUERY, 6'd63, 6'd2);
    send_item(OP_QUERY, 6'd63, 6'd63);
    send_item(OP_QUERY, 6'd2, 6'd1);
    send_item(OP_UNUSED, 6'd63, 6'd63);
    send_item(OP_ADD, 6'd5, 6'd6);
    write_node_count(7'd3);
    send_item(OP_QUERY, 6'd5, 6'd5);
    send_item(OP_QUERY, 6'd0, 6'd2);
    send_item(OP_QUERY, 6'd2, 6'd0);
    write_node_count(7'd0);
    send_item(OP_QUERY, 6'd0, 6'd0);
    write_node_count(7'd127);
    send_item(OP_QUERY, 6'd5, 6'd6);
    write_node_count(7'd1);
    send_item(OP_QUERY, 6'd0, 6'd0);
    send_item(OP_QUERY, 6'd0, 6'd1);
    write_node_count(7'd64);
    send_item(OP_CLEAR, 6'd0, 6'd0);
    send_item(OP_QUERY, 6'd0, 6'd1);
    send_item(OP_QUERY, 6'd63, 6'd0);

    sent = 0;
    while (sent < 880) run_phase($urandom_range(40, 100), sent);

    start = 1'b0;
    waited = 0;
    while (mirror.pending_hops.size() != 0 && waited < 4 * DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    mirror.check_drained();
    if (mirror.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("simulation failed");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hdl
hdl/bhd_pkg.sv
hdl/bhd_ram.sv
hdl/bfs_hop_distance_core.sv
hdl/bhd_checker.sv
tb/tb_top.sv
